@@ rtl/core/sorted_byte_list_engine_core_macros.svh @@
// assertion macros for the sorted byte list engine checker
`ifndef SORTED_BYTE_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_BYTE_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SBLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SBLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sble_pkg.sv @@
// shared constants, codes and types of the sorted byte list engine
`default_nettype none

package sble_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_SET    = 3'd3,
        ACT_GET    = 3'd4,
        ACT_FIND   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ORDER    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADINDEX = 3'd4
    } status_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] value;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic below;
        logic valid;
    } cell_loc_t;

    typedef struct packed {
        logic first_eq;
        logic last_gt;
        logic set_bad;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/sble_cell.sv @@
// one list entry with its compare flags and neighbour shift logic
`default_nettype none

module sble_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sble_pkg::cmd_t         cmd,
    input  wire sble_pkg::cell_loc_t    loc,
    input  wire logic                   left_valid,
    // every entry to the left is smaller than the value
    input  wire logic                   left_lt,
    // an entry to the left equals the value
    input  wire logic                   left_eq,
    input  wire logic [7:0]             left_entry,
    input  wire logic                   right_valid,
    input  wire logic [7:0]             right_entry,
    output logic [7:0]                  entry,
    output logic                        lt,
    output logic                        eq,
    output sble_pkg::cell_flags_t       flags,
    output logic [7:0]                  rd
);
    import sble_pkg::*;

    logic [7:0] entry_reg;
    logic [7:0] entry_next;
    logic       here_lt;
    logic       here_eq;

    assign entry   = entry_reg;
    assign here_lt = loc.valid && (entry_reg < cmd.value);
    assign here_eq = loc.valid && (entry_reg == cmd.value);
    assign lt      = left_lt && here_lt;
    assign eq      = left_eq || here_eq;

    assign flags.first_eq = here_eq && !left_eq;
    assign flags.last_gt  = loc.valid && !right_valid && (entry_reg > cmd.value);
    assign flags.set_bad  = loc.hit && loc.valid &&
                            ((left_entry > cmd.value) ||
                             (right_valid && (right_entry < cmd.value)));
    assign rd = (loc.hit && loc.valid) ? entry_reg : 8'd0;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.commit)
        begin
            case (cmd.action)
                ACT_INSERT:
                begin
                    if (!lt)
                    begin
                        entry_next = left_lt ? cmd.value : left_entry;
                    end
                end
                ACT_DELETE:
                begin
                    if (loc.valid && eq)
                    begin
                        entry_next = right_valid ? right_entry : 8'd0;
                    end
                end
                ACT_APPEND:
                begin
                    if (!loc.valid && left_valid)
                    begin
                        entry_next = cmd.value;
                    end
                end
                ACT_SET:
                begin
                    if (loc.hit)
                    begin
                        entry_next = cmd.value;
                    end
                    else if (!loc.valid && loc.below)
                    begin
                        entry_next = 8'd0;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= 8'd0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_byte_list_engine_core.sv @@
// An ascending list of up to 64 bytes held in a row of compare-and-shift cells.
// Each beat carries one operation (insert, delete, append, set, get, find) and
// yields one result beat. Every cell compares its entry with the beat's value and
// takes its new entry from itself, its left or right neighbour, the value or zero, so
// an operation completes in the cycle it is accepted; the result is registered and
// shows in the next cycle. A new beat is taken every cycle in which the result
// register is empty or being drained, giving one item per cycle sustained.
`default_nettype none

module sorted_byte_list_engine_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // action[2:0], value[10:3], position[16:11], zero pad
    input  wire logic [sble_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // status[2:0], read_value[10:3], match_index[16:11], entry_count[23:17]
    output logic [sble_pkg::OUT_W-1:0]      m_axis_tdata
);
    import sble_pkg::*;

    logic                 fire;
    action_t              action;
    logic [7:0]           value;
    logic [5:0]           position;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 pos_in;
    logic                 full;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    cmd_t                 cmd;
    cell_loc_t            loc    [DEPTH];
    logic [7:0]           entry  [DEPTH];
    logic                 lt     [DEPTH];
    logic                 eq     [DEPTH];
    cell_flags_t          flags  [DEPTH];
    logic [7:0]           rd     [DEPTH];

    logic                 found;
    logic                 last_gt;
    logic                 set_bad;
    logic [7:0]           rd_any;
    logic [IDX_W-1:0]     match_idx;
    status_t              status;
    logic [7:0]           read_value;
    logic [5:0]           match_index;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign action   = action_t'(s_axis_tdata[2:0]);
    assign value    = s_axis_tdata[10:3];
    assign position = s_axis_tdata[16:11];
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_in   = pos_ext < cnt_ext;
    assign full     = count_reg == CNT_W'(DEPTH);

    assign cmd.action = action;
    assign cmd.value  = value;
    assign cmd.commit = fire && (status == ST_OK);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign loc[gi].hit   = pos_ext == CMP_W'(gi);
            assign loc[gi].below = CMP_W'(gi) < pos_ext;
            assign loc[gi].valid = CMP_W'(gi) < cnt_ext;

            if (gi == 0)
            begin : g_first
                sble_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .loc         (loc[gi]),
                    .left_valid  (1'b1),
                    .left_lt     (1'b1),
                    .left_eq     (1'b0),
                    .left_entry  (8'd0),
                    .right_valid (loc[gi+1].valid),
                    .right_entry (entry[gi+1]),
                    .entry       (entry[gi]),
                    .lt          (lt[gi]),
                    .eq          (eq[gi]),
                    .flags       (flags[gi]),
                    .rd          (rd[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_last
                sble_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .loc         (loc[gi]),
                    .left_valid  (loc[gi-1].valid),
                    .left_lt     (lt[gi-1]),
                    .left_eq     (eq[gi-1]),
                    .left_entry  (entry[gi-1]),
                    .right_valid (1'b0),
                    .right_entry (8'd0),
                    .entry       (entry[gi]),
                    .lt          (lt[gi]),
                    .eq          (eq[gi]),
                    .flags       (flags[gi]),
                    .rd          (rd[gi])
                );
            end
            else
            begin : g_mid
                sble_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .loc         (loc[gi]),
                    .left_valid  (loc[gi-1].valid),
                    .left_lt     (lt[gi-1]),
                    .left_eq     (eq[gi-1]),
                    .left_entry  (entry[gi-1]),
                    .right_valid (loc[gi+1].valid),
                    .right_entry (entry[gi+1]),
                    .entry       (entry[gi]),
                    .lt          (lt[gi]),
                    .eq          (eq[gi]),
                    .flags       (flags[gi]),
                    .rd          (rd[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        found     = 1'b0;
        last_gt   = 1'b0;
        set_bad   = 1'b0;
        rd_any    = 8'd0;
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found   = found   | flags[i].first_eq;
            last_gt = last_gt | flags[i].last_gt;
            set_bad = set_bad | flags[i].set_bad;
            rd_any  = rd_any  | rd[i];
            if (flags[i].first_eq)
            begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        status      = ST_OK;
        read_value  = 8'd0;
        match_index = 6'd0;
        count_next  = count_reg;
        unique case (action)
            ACT_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                if (!found)
                begin
                    status = ST_NOTFOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_APPEND:
            begin
                if (last_gt && (value != 8'd0))
                begin
                    status = ST_ORDER;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_SET:
            begin
                if (pos_in)
                begin
                    if (set_bad)
                    begin
                        status = ST_ORDER;
                    end
                end
                else if (last_gt)
                begin
                    status = ST_ORDER;
                end
                else if (pos_ext >= CMP_W'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = CNT_W'(pos_ext + CMP_W'(1));
                end
            end
            ACT_GET:
            begin
                if (!pos_in)
                begin
                    status = ST_BADINDEX;
                end
                else
                begin
                    read_value = rd_any;
                end
            end
            ACT_FIND:
            begin
                if (!found)
                begin
                    status = ST_NOTFOUND;
                end
                else
                begin
                    match_index = 6'(match_idx);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {7'(count_next), match_index, read_value, status};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sble_checker.sv @@
// port-level checks of the sorted byte list engine and their binding
`default_nettype none

`include "sorted_byte_list_engine_core_macros.svh"

module sble_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic [sble_pkg::IN_W-1:0]  s_axis_tdata,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [sble_pkg::OUT_W-1:0] m_axis_tdata
);
    import sble_pkg::*;

    logic       in_beat;
    logic       out_stall;
    logic [2:0] st;
    logic [6:0] cnt;

    assign in_beat   = s_axis_tvalid && s_axis_tready && (s_axis_tdata[23:17] == 7'd0);
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign st        = m_axis_tdata[2:0];
    assign cnt       = m_axis_tdata[23:17];

    `SBLE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result beat dropped while stalled")

    `SBLE_ASSERT_NEXT(a_beat_result, in_beat, m_axis_tvalid, "accepted beat gave no result")

    `SBLE_ASSERT_NOW(a_fields_range, m_axis_tvalid, (st <= ST_BADINDEX) && (cnt <= 7'(DEPTH)), "result status or count out of range")

    `SBLE_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (st != ST_OK), m_axis_tdata[16:3] == 14'd0, "failed operation returned data")

endmodule

bind sorted_byte_list_engine_core sble_checker u_sble_checker (.*);

`default_nettype wire

@@ test/sorted_byte_list_engine_core_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the sorted byte list engine core with a predicting scoreboard

module sorted_byte_list_engine_core_test;
    import sble_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 667;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [6:0] pad;
        logic [5:0] position;
        logic [7:0] value;
        logic [2:0] action;
    } list_op_t;

    typedef struct packed {
        logic [6:0] entry_count;
        logic [5:0] match_index;
        logic [7:0] read_value;
        logic [2:0] status;
    } list_result_t;

    class list_scoreboard;
        logic [7:0] entries [DEPTH];
        int count;
        int failures;
        list_result_t pending_q [$];

        function new();
            foreach (entries[j])
                entries[j] = 8'h00;
            count = 0;
            failures = 0;
        endfunction

        function void note_op(list_op_t op);
            list_result_t res;
            int i;
            int k;
            int pos;
            logic [7:0] v;
            res = '0;
            res.status = ST_OK;
            v = op.value;
            pos = int'(op.position);
            case (op.action)
                ACT_INSERT:
                begin
                    if (count >= DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        i = 0;
                        while (i < count && entries[i] < v)
                            i++;
                        for (k = count; k > i; k--)
                            entries[k] = entries[k - 1];
                        entries[i] = v;
                        count++;
                    end
                end
                ACT_DELETE:
                begin
                    i = 0;
                    while (i < count && entries[i] != v)
                        i++;
                    if (i >= count)
                        res.status = ST_NOTFOUND;
                    else
                    begin
                        for (k = i; k < count - 1; k++)
                            entries[k] = entries[k + 1];
                        entries[count - 1] = 8'h00;
                        count--;
                    end
                end
                ACT_APPEND:
                begin
                    if (count > 0 && entries[count - 1] > v && v != 8'h00)
                        res.status = ST_ORDER;
                    else if (count >= DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        entries[count] = v;
                        count++;
                    end
                end
                ACT_SET:
                begin
                    if (pos >= count)
                    begin
                        if (count > 0 && v < entries[count - 1])
                            res.status = ST_ORDER;
                        else if (pos >= DEPTH)
                            res.status = ST_FULL;
                        else
                        begin
                            for (k = count; k < pos; k++)
                                entries[k] = 8'h00;
                            entries[pos] = v;
                            count = pos + 1;
                        end
                    end
                    else if ((pos > 0 && entries[pos - 1] > v) ||
                             (pos + 1 < count && entries[pos + 1] < v))
                        res.status = ST_ORDER;
                    else
                        entries[pos] = v;
                end
                ACT_GET:
                begin
                    if (pos >= count)
                        res.status = ST_BADINDEX;
                    else
                        res.read_value = entries[pos];
                end
                ACT_FIND:
                begin
                    i = 0;
                    while (i < count && entries[i] != v)
                        i++;
                    if (i >= count)
                        res.status = ST_NOTFOUND;
                    else
                        res.match_index = i[5:0];
                end
                default:
                begin
                end
            endcase
            res.entry_count = count[6:0];
            pending_q.push_back(res);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result beat %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.match_index !== want.match_index || got.entry_count !== want.entry_count)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("result mismatch (expected/actual): status %0d/%0d read_value %0d/%0d",
                             want.status, got.status, want.read_value, got.read_value);
                    $display("    match_index %0d/%0d entry_count %0d/%0d",
                             want.match_index, got.match_index,
                             want.entry_count, got.entry_count);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;

    logic               hold_active = 1'b0;
    int                 send_idle_pct = 24;
    int                 recv_idle_pct = 75;
    int                 idle_cycles = 0;
    list_scoreboard     sb;

    sorted_byte_list_engine_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // beats are sampled at the falling clock edge ahead of the rising edge that takes them
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_op(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    task automatic send_op(input list_op_t op);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= op;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_fields(input logic [2:0] act, input logic [7:0] v,
                               input logic [5:0] pos);
        list_op_t op;
        op = '0;
        op.action = act;
        op.value = v;
        op.position = pos;
        send_op(op);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic list_op_t make_op(bit growing);
        list_op_t op;
        int r;
        int cnt;
        int p;
        logic [7:0] lo;
        logic [7:0] hi;
        op = '0;
        cnt = sb.count;
        r = $urandom_range(0, 99);
        if (growing)
            op.action = (r < 35) ? ACT_INSERT : (r < 55) ? ACT_APPEND : (r < 65) ? ACT_DELETE :
                        (r < 75) ? ACT_SET : (r < 85) ? ACT_GET : (r < 95) ? ACT_FIND :
                        ($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO);
        else
            op.action = (r < 15) ? ACT_INSERT : (r < 20) ? ACT_APPEND : (r < 60) ? ACT_DELETE :
                        (r < 70) ? ACT_SET : (r < 80) ? ACT_GET : (r < 95) ? ACT_FIND :
                        ($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO);
        op.value = 8'($urandom_range(0, 255));
        op.position = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            op.value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else if (cnt > 0 && (op.action == ACT_DELETE || op.action == ACT_FIND) &&
                 $urandom_range(0, 9) < 7)
            op.value = sb.entries[$urandom_range(0, cnt - 1)];
        else if (cnt > 0 && op.action == ACT_APPEND && $urandom_range(0, 3) != 0)
            op.value = 8'($urandom_range(sb.entries[cnt - 1], 255));
        if (op.action == ACT_GET && cnt > 0 && $urandom_range(0, 3) != 0)
            op.position = 6'($urandom_range(0, cnt - 1));
        if (op.action == ACT_SET)
        begin
            r = $urandom_range(0, 9);
            if (cnt > 0 && r < 6)
            begin
                p = $urandom_range(0, cnt - 1);
                lo = (p > 0) ? sb.entries[p - 1] : 8'h00;
                hi = (p + 1 < cnt) ? sb.entries[p + 1] : 8'hFF;
                op.position = 6'(p);
                op.value = 8'($urandom_range(lo, hi));
            end
            else if (r < 8)
            begin
                p = cnt + $urandom_range(0, 3);
                op.position = (p > 63) ? 6'd63 : 6'(p);
                if (cnt > 0)
                    op.value = 8'($urandom_range(sb.entries[cnt - 1], 255));
            end
        end
        return op;
    endfunction

    initial
    begin
        int phase;
        int n;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // corner cases starting from an empty list
        send_fields(ACT_GET,    8'd0,   6'd0);
        send_fields(ACT_FIND,   8'd5,   6'd0);
        send_fields(ACT_DELETE, 8'd7,   6'd0);
        send_fields(ACT_APPEND, 8'd200, 6'd0);
        send_fields(ACT_APPEND, 8'd100, 6'd0);
        send_fields(ACT_APPEND, 8'd0,   6'd0);
        send_fields(ACT_INSERT, 8'd0,   6'd0);
        send_fields(ACT_INSERT, 8'd255, 6'd0);
        send_fields(ACT_INSERT, 8'd128, 6'd0);
        send_fields(ACT_DELETE, 8'd255, 6'd0);
        send_fields(ACT_FIND,   8'd0,   6'd0);
        send_fields(ACT_FIND,   8'd200, 6'd0);
        send_fields(ACT_GET,    8'd0,   6'd2);
        send_fields(ACT_SET,    8'd250, 6'd1);
        send_fields(ACT_SET,    8'd3,   6'd10);
        send_fields(ACT_SET,    8'd1,   6'd20);
        // padding out to a full list, then full-list and spare-action cases
        send_fields(ACT_SET,    8'd255, 6'd63);
        send_fields(ACT_INSERT, 8'd9,   6'd0);
        send_fields(ACT_APPEND, 8'd255, 6'd0);
        send_fields(ACT_APPEND, 8'd7,   6'd0);
        send_fields(ACT_APPEND, 8'd0,   6'd0);
        send_fields(ACT_GET,    8'd0,   6'd63);
        send_fields(ACT_DELETE, 8'd0,   6'd0);
        send_fields(ACT_SPARE_LO, 8'hAA, 6'h2A);
        send_fields(ACT_SPARE_HI, 8'h55, 6'h15);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 24 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == 200)
                begin
                    fork
                        begin
                            hold_active <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge clk);
                            hold_active <= 1'b0;
                        end
                    join_none
                end
                send_op(make_op(((n / 80) % 2) == 0));
            end
            wait_drained();
        end

        if (sb.failures == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
